FILE: src/i2cm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the I2C master bit sequencer.
// No dependencies; imported by i2cm_core and i2c_master_bit_sequencer.
package i2cm_pkg;

   localparam logic [2:0] REQ_TICK  = 3'd0;
   localparam logic [2:0] REQ_START = 3'd1;
   localparam logic [2:0] REQ_STOP  = 3'd2;
   localparam logic [2:0] REQ_ADDR  = 3'd3;
   localparam logic [2:0] REQ_WRITE = 3'd4;
   localparam logic [2:0] REQ_READ  = 3'd5;

   localparam logic [6:0]  ADDR_MIN      = 7'd8;
   localparam logic [6:0]  ADDR_MAX      = 7'd120;
   localparam logic [15:0] PHASE_RST     = 16'd100;
   localparam logic [3:0]  ACK_BIT_INDEX = 4'd8;

   typedef enum logic [2:0] {
      OP_IDLE  = 3'd0,
      OP_START = 3'd1,
      OP_STOP  = 3'd2,
      OP_ADDR  = 3'd3,
      OP_WRITE = 3'd4,
      OP_READ  = 3'd5
   } op_type;

   typedef struct packed {
      logic scl;
      logic sda;
      logic drv;
   } lines_type;

   localparam lines_type LINES_RST = '{scl: 1'b1, sda: 1'b1, drv: 1'b1};

   typedef struct packed {
      logic [2:0] req;
      logic [7:0] tx_byte;
      logic       rw_bit;
      logic       nack_last;
      logic       sda_in;
   } cmd_type;

   typedef struct packed {
      lines_type  lines;
      logic       busy;
      logic       done;
      logic [7:0] rx_byte;
      logic       ack;
      logic       err;
   } res_type;

   // Line levels for the low phase of bit bi.
   function automatic lines_type bit_lines(input op_type op, input logic [3:0] bi,
                                           input logic [7:0] sh);
      lines_type l;
      l.scl = 1'b0;
      if (op == OP_READ) begin
         l.sda = (bi < ACK_BIT_INDEX) ? 1'b1 : sh[0];
         l.drv = (bi < ACK_BIT_INDEX) ? 1'b0 : 1'b1;
      end else begin
         l.sda = (bi < ACK_BIT_INDEX) ? sh[3'd7 - bi[2:0]] : 1'b1;
         l.drv = (bi < ACK_BIT_INDEX) ? 1'b1 : 1'b0;
      end
      return l;
   endfunction

endpackage

FILE: src/i2cm_core.sv
`timescale 1ns / 1ps
// Sequencer state and per-tick next-state logic; one tick per step.
// Depends on i2cm_pkg.
module i2cm_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  i2cm_pkg::cmd_type cmd,
   input  logic [15:0]       phase_ticks,
   output i2cm_pkg::res_type res
);
   import i2cm_pkg::*;

   op_type     op_ff, op_in;
   logic       phase_ff, phase_in;
   logic [15:0] tick_ff, tick_in;
   logic [3:0] bit_ff, bit_in;
   logic [7:0] shift_ff, shift_in;
   logic [7:0] rx_ff, rx_in;
   lines_type  lines_ff, lines_in;
   logic       ack_ff, ack_in;

   logic [16:0] tick_sum;
   logic [16:0] lim;
   logic [6:0]  addr;
   logic [3:0]  bit_nxt;
   logic        fin;
   logic        done;
   logic        err;

   assign tick_sum = {1'b0, tick_ff} + 17'd1;
   assign lim      = (phase_ticks == 16'd0) ? 17'd1 : {1'b0, phase_ticks};
   assign addr     = cmd.tx_byte[6:0];
   assign bit_nxt  = bit_ff + 4'd1;

   always_comb begin
      op_in    = op_ff;
      phase_in = phase_ff;
      tick_in  = tick_ff;
      bit_in   = bit_ff;
      shift_in = shift_ff;
      rx_in    = rx_ff;
      lines_in = lines_ff;
      ack_in   = ack_ff;
      fin      = 1'b0;
      done     = 1'b0;
      err      = 1'b0;
      if (op_ff == OP_IDLE) begin
         unique case (cmd.req)
            REQ_START: begin
               op_in    = OP_START;
               phase_in = 1'b0;
               tick_in  = '0;
               lines_in = '{scl: 1'b1, sda: 1'b1, drv: 1'b1};
            end
            REQ_STOP: begin
               op_in    = OP_STOP;
               phase_in = 1'b0;
               tick_in  = '0;
               lines_in = '{scl: 1'b0, sda: 1'b0, drv: 1'b1};
            end
            REQ_ADDR: begin
               if (addr < ADDR_MIN || addr > ADDR_MAX) begin
                  err    = 1'b1;
                  done   = 1'b1;
                  ack_in = 1'b1;
               end else begin
                  op_in    = OP_ADDR;
                  shift_in = {addr, cmd.rw_bit};
                  bit_in   = '0;
                  phase_in = 1'b0;
                  tick_in  = '0;
                  lines_in = bit_lines(OP_ADDR, 4'd0, {addr, cmd.rw_bit});
               end
            end
            REQ_WRITE: begin
               op_in    = OP_WRITE;
               shift_in = cmd.tx_byte;
               bit_in   = '0;
               phase_in = 1'b0;
               tick_in  = '0;
               lines_in = bit_lines(OP_WRITE, 4'd0, cmd.tx_byte);
            end
            REQ_READ: begin
               op_in    = OP_READ;
               rx_in    = '0;
               shift_in = {7'd0, cmd.nack_last};
               bit_in   = '0;
               phase_in = 1'b0;
               tick_in  = '0;
               lines_in = bit_lines(OP_READ, 4'd0, {7'd0, cmd.nack_last});
            end
            default: ;
         endcase
      end else begin
         tick_in = tick_sum[15:0];
         if (tick_sum >= lim) begin
            tick_in = '0;
            unique case (op_ff)
               OP_START: begin
                  if (!phase_ff) begin
                     phase_in = 1'b1;
                     lines_in = '{scl: 1'b1, sda: 1'b0, drv: 1'b1};
                  end else begin
                     lines_in = '{scl: 1'b0, sda: 1'b0, drv: 1'b1};
                     fin      = 1'b1;
                  end
               end
               OP_STOP: begin
                  if (!phase_ff) begin
                     phase_in = 1'b1;
                     lines_in = '{scl: 1'b1, sda: 1'b0, drv: 1'b1};
                  end else begin
                     lines_in = '{scl: 1'b1, sda: 1'b1, drv: 1'b1};
                     fin      = 1'b1;
                  end
               end
               default: begin
                  if (!phase_ff) begin
                     phase_in     = 1'b1;
                     lines_in.scl = 1'b1;
                  end else if (bit_ff >= ACK_BIT_INDEX) begin
                     if (op_ff == OP_READ) begin
                        lines_in = '{scl: 1'b0, sda: shift_ff[0], drv: 1'b1};
                     end else begin
                        ack_in   = cmd.sda_in;
                        lines_in = '{scl: 1'b0, sda: 1'b1, drv: 1'b1};
                     end
                     fin = 1'b1;
                  end else begin
                     if (op_ff == OP_READ) begin
                        rx_in = {rx_ff[6:0], cmd.sda_in};
                     end
                     bit_in   = bit_nxt;
                     phase_in = 1'b0;
                     lines_in = bit_lines(op_ff, bit_nxt, shift_ff);
                  end
               end
            endcase
            if (fin) begin
               done     = 1'b1;
               op_in    = OP_IDLE;
               phase_in = 1'b0;
               bit_in   = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff    <= OP_IDLE;
         phase_ff <= 1'b0;
         tick_ff  <= '0;
         bit_ff   <= '0;
         shift_ff <= '0;
         rx_ff    <= '0;
         lines_ff <= LINES_RST;
         ack_ff   <= 1'b1;
      end else if (step) begin
         op_ff    <= op_in;
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         bit_ff   <= bit_in;
         shift_ff <= shift_in;
         rx_ff    <= rx_in;
         lines_ff <= lines_in;
         ack_ff   <= ack_in;
      end
   end

   assign res.lines   = lines_in;
   assign res.busy    = (op_in != OP_IDLE);
   assign res.done    = done;
   assign res.rx_byte = rx_in;
   assign res.ack     = ack_in;
   assign res.err     = err;

endmodule

FILE: src/i2c_master_bit_sequencer.sv
`timescale 1ns / 1ps
// Top level of the I2C master bit sequencer: input register, core, result register.
// Depends on i2cm_pkg and i2cm_core.
//
//   channel | dir | beat
//   req_    | in  | one tick: command fields and sampled SDA
//   rsp_    | out | line levels and status after that tick
//   csr_    | in  | phase_ticks write (ticks per half-bit phase)
//
// One tick per clock while rsp_ready is high; rsp_valid rises once an accepted
// req beat has moved from the input register into the result register.
// The core state advances as a tick moves from the input register to the
// result register, so throughput is one beat per cycle with rsp_ready high.
// A stalled rsp_ holds the result; req_ready then drops once the input
// register is also full. Synchronous reset; phase_ticks resets to 100.
module i2c_master_bit_sequencer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_type,
   input  logic [7:0]  req_tx_byte,
   input  logic        req_rw_bit,
   input  logic        req_nack_last,
   input  logic        req_sda_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_scl_out,
   output logic        rsp_sda_out,
   output logic        rsp_sda_drive,
   output logic        rsp_busy_res,
   output logic        rsp_done_res,
   output logic [7:0]  rsp_rx_byte,
   output logic        rsp_ack_bit,
   output logic        rsp_addr_error,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_phase_ticks
);
   import i2cm_pkg::*;

   logic        in_vld_ff, in_vld_in;
   cmd_type     cmd_ff;
   logic        out_vld_ff, out_vld_in;
   res_type     res_ff;
   res_type     res_nxt;
   logic [15:0] phase_ff;
   logic        adv;

   assign adv       = in_vld_ff && (!out_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || adv;
   assign csr_ready = 1'b1;

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_valid && req_ready) begin
         in_vld_in = 1'b1;
      end else if (adv) begin
         in_vld_in = 1'b0;
      end
      out_vld_in = out_vld_ff;
      if (adv) begin
         out_vld_in = 1'b1;
      end else if (rsp_ready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         phase_ff   <= PHASE_RST;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         if (csr_valid && csr_ready) begin
            phase_ff <= csr_phase_ticks;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         cmd_ff <= '{req: req_type, tx_byte: req_tx_byte, rw_bit: req_rw_bit,
                     nack_last: req_nack_last, sda_in: req_sda_in};
      end
      if (adv) begin
         res_ff <= res_nxt;
      end
   end

   i2cm_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step       (adv),
      .cmd        (cmd_ff),
      .phase_ticks(phase_ff),
      .res        (res_nxt)
   );

   assign rsp_valid      = out_vld_ff;
   assign rsp_scl_out    = res_ff.lines.scl;
   assign rsp_sda_out    = res_ff.lines.sda;
   assign rsp_sda_drive  = res_ff.lines.drv;
   assign rsp_busy_res   = res_ff.busy;
   assign rsp_done_res   = res_ff.done;
   assign rsp_rx_byte    = res_ff.rx_byte;
   assign rsp_ack_bit    = res_ff.ack;
   assign rsp_addr_error = res_ff.err;

endmodule

FILE: src/i2cm_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the I2C master bit sequencer, bound to the top level.
// Depends only on the top level's ports.
module i2cm_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_scl_out,
   input logic       rsp_sda_out,
   input logic       rsp_sda_drive,
   input logic       rsp_busy_res,
   input logic       rsp_done_res,
   input logic [7:0] rsp_rx_byte,
   input logic       rsp_addr_error
);

   a_err_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_addr_error |-> rsp_done_res)
      else $error("addr_error without done");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_busy_res)
      else $error("done beat still busy");

   a_release_high: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_sda_drive |-> rsp_sda_out)
      else $error("released SDA not high");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_rx_byte)
         && $stable(rsp_scl_out))
      else $error("stalled result beat changed");

endmodule

bind i2c_master_bit_sequencer i2cm_checker u_i2cm_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_scl_out   (rsp_scl_out),
   .rsp_sda_out   (rsp_sda_out),
   .rsp_sda_drive (rsp_sda_drive),
   .rsp_busy_res  (rsp_busy_res),
   .rsp_done_res  (rsp_done_res),
   .rsp_rx_byte   (rsp_rx_byte),
   .rsp_addr_error(rsp_addr_error)
);
